@@ sv/bffg_pkg.sv @@
// Shared types and constants of the burst-fire frame gate.
// Used by bffg_cell and burst_fire_frame_gate; depends on nothing.
`default_nettype none
package bffg_pkg;

	localparam int LEVEL_W   = 7;
	localparam int REG_COUNT = 4;
	localparam int CFG_IDX_W = 3;
	localparam int FIELD_W   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL3 = 3'd4;

	// One quotient bit handed from a divider cell to its neighbor.
	typedef struct packed {
		logic en;
		logic qbit;
	} cell_link_t;

endpackage
`default_nettype wire

@@ sv/bffg_cell.sv @@
// Bit-serial restoring divider cell: one dividend bit in and one quotient bit out
// per cycle while link_in.en is set. Depends on bffg_pkg.
`default_nettype none
module bffg_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [bffg_pkg::LEVEL_W-1:0]    divisor,
	input  wire bffg_pkg::cell_link_t            link_in,
	output bffg_pkg::cell_link_t                 link_out,
	output logic                                 pass
);
	import bffg_pkg::*;

	logic [LEVEL_W-1:0] rem_q;
	logic [LEVEL_W:0]   trial;
	logic [LEVEL_W:0]   diff;
	logic               fits;
	cell_link_t         link_q;

	assign trial = {rem_q, link_in.qbit};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.en   <= link_in.en;
			link_q.qbit <= fits;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
		end else if (link_in.en) begin
			rem_q <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
		end
	end

	assign link_out = link_q;
	assign pass     = (divisor != '0) && (rem_q == '0);

endmodule
`default_nettype wire

@@ sv/burst_fire_frame_gate.sv @@
// Burst-fire relay gate: each zero-crossing transaction with zero_cross set returns the relay
// level decided at the previous crossing and the new frame index, then decides the level of the
// new frame. Depends on bffg_pkg and bffg_cell.
//
// A crossing transaction is followed by the next one only after the frame number has walked
// bit-serially, most significant bit first, through the row of divider cells; each cell divides
// the quotient of its left neighbor by its pattern level. Transactions with zero_cross clear are
// accepted while idle and return nothing. The result goes into an output register backed by one
// skid entry, so one stalled result does not hold up the next crossing, but no transaction is
// accepted while the skid entry is full. Configuration writes are taken every cycle.
`default_nettype none
module burst_fire_frame_gate #(
	parameter int FRAME_COUNT = 100,
	parameter int LEVELS      = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,   // [0] zero_cross
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [7:0]                            m_tdata,   // [0] ssr_drive, [7:1] frame_index
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bffg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bffg_pkg::LEVEL_W-1:0]     cfg_data
);
	import bffg_pkg::*;

	localparam int FRAME_W = $clog2(FRAME_COUNT + 1);
	localparam int NCELL   = (LEVELS < REG_COUNT) ? LEVELS : REG_COUNT;
	localparam int LAST    = FRAME_W + NCELL - 1;
	localparam int STEP_W  = $clog2(LAST + 1);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [FRAME_W-1:0]   frame_sh_q;
	logic [FRAME_W-1:0]   frame_nxt;
	logic                 next_level_q;
	logic                 invert_q;
	logic [LEVEL_W-1:0]   level_q [REG_COUNT];
	logic                 out_valid_q;
	logic                 out_drive_q;
	logic [FIELD_W-1:0]   out_frame_q;
	logic                 skid_valid_q;
	logic                 skid_drive_q;
	logic [FIELD_W-1:0]   skid_frame_q;
	logic                 accept;
	logic                 push;
	logic                 take;
	logic                 start;
	logic [NCELL-1:0]     pass;
	cell_link_t           lnk [NCELL+1];
	logic                 run_ok;
	logic                 parity;
	logic [1:0]           lvl_sel;

	assign s_tready  = (state_q == ST_IDLE) && !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign push      = accept && s_tdata[0];
	assign take      = out_valid_q && m_tready;
	assign start     = push;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {out_frame_q, out_drive_q};
	assign lvl_sel   = 2'(cfg_index - REG_LEVEL0);

	assign frame_nxt = (frame_q >= FRAME_W'(FRAME_COUNT)) ? FRAME_W'(1) : frame_q + FRAME_W'(1);

	assign lnk[0].en   = (state_q == ST_RUN) && (step_q < STEP_W'(FRAME_W));
	assign lnk[0].qbit = frame_sh_q[FRAME_W-1];

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		bffg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (start),
			.divisor  (level_q[k]),
			.link_in  (lnk[k]),
			.link_out (lnk[k+1]),
			.pass     (pass[k])
		);
	end

	always_comb begin
		run_ok = 1'b1;
		parity = 1'b0;
		for (int k = 0; k < NCELL; k++) begin
			run_ok = run_ok & pass[k];
			parity = parity ^ run_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			for (int k = 0; k < REG_COUNT; k++) begin
				level_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_INVERT) begin
				invert_q <= cfg_data[0];
			end else if (cfg_index inside {[REG_LEVEL0:REG_LEVEL3]}) begin
				level_q[lvl_sel] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			frame_q      <= FRAME_W'(1);
			frame_sh_q   <= '0;
			next_level_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_drive_q  <= 1'b0;
			out_frame_q  <= '0;
			skid_valid_q <= 1'b0;
			skid_drive_q <= 1'b0;
			skid_frame_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q    <= ST_RUN;
						step_q     <= '0;
						frame_q    <= frame_nxt;
						frame_sh_q <= frame_nxt;
					end
				end
				ST_RUN: begin
					frame_sh_q <= frame_sh_q << 1;
					if (step_q == STEP_W'(LAST)) begin
						state_q      <= ST_IDLE;
						next_level_q <= parity ^ invert_q;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (take) begin
				if (skid_valid_q) begin
					out_drive_q  <= skid_drive_q;
					out_frame_q  <= skid_frame_q;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
					out_drive_q <= next_level_q;
					out_frame_q <= FIELD_W'(frame_nxt);
				end
			end else if (push) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
					skid_drive_q <= next_level_q;
					skid_frame_q <= FIELD_W'(frame_nxt);
				end else begin
					out_valid_q <= 1'b1;
					out_drive_q <= next_level_q;
					out_frame_q <= FIELD_W'(frame_nxt);
				end
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[0]) |=> m_tvalid)
		else $error("accepted crossing produced no result");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_q >= FRAME_W'(1)) && (frame_q <= FRAME_W'(FRAME_COUNT)))
		else $error("frame counter out of range");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !s_tready)
		else $error("input accepted during level walk");

endmodule
`default_nettype wire
